/* rtl/gvm_pkg.sv */
// Shared types, constants and helper functions for the granular voice mixer.
`default_nettype none

package gvm_pkg;

  // Field widths
  localparam int OP_W        = 2;
  localparam int ADDR_W      = 16;
  localparam int SAMPLE_W    = 16;
  localparam int SLICE_W     = 17;
  localparam int RAND_W      = 32;
  localparam int POS_W       = 17;
  localparam int FRAC_W      = 16;
  localparam int GLEN_W      = 11;
  localparam int ENV_W       = 10;
  localparam int SPM_W       = 8;
  localparam int MIX_W       = 9;
  localparam int MS_W        = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  // Ramp divider sizes: |sample| * distance * 2^16 over fraction * stop
  localparam int DIV_NUM_W = SAMPLE_W + POS_W + FRAC_W;
  localparam int DIV_DEN_W = FRAC_W + POS_W;
  localparam int DIV_Q_W   = 16;

  // Parameter defaults
  localparam int DEF_VOICE_COUNT  = 30;
  localparam int DEF_CORPUS_DEPTH = 65536;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_GRAIN  = 2'd1;
  localparam logic [OP_W-1:0] OP_RENDER = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_GRAIN_LEN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENV_SHAPE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPM       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PASS      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MIX       = 3'd4;

  // Register reset values
  localparam logic [GLEN_W-1:0] GLEN_RESET = 11'd200;
  localparam logic [ENV_W-1:0]  ENV_RESET  = 10'd256;
  localparam logic [SPM_W-1:0]  SPM_RESET  = 8'd96;
  localparam logic [MIX_W-1:0]  MIX_RESET  = 9'd256;

  localparam logic [ENV_W-1:0] ENV_MAX     = 10'd512;
  localparam logic [MIX_W-1:0] MIX_FULL    = 9'd256;
  localparam logic [MS_W-1:0]  MIN_GRAIN_MS = 12'd20;
  localparam logic [1:0]       PRESET_LAST = 2'd2;

  localparam logic signed [31:0] SAT_HI = 32'sd32767;
  localparam logic signed [31:0] SAT_LO = -32'sd32768;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  stop;
    logic [FRAC_W-1:0] att;
    logic [FRAC_W-1:0] dec;
  } voice_t;

  function automatic logic [FRAC_W-1:0] att_preset(input logic [1:0] idx);
    case (idx)
      2'd0:    return 16'd3277;
      2'd1:    return 16'd6554;
      default: return 16'd55706;
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] dec_preset(input logic [1:0] idx);
    case (idx)
      2'd0:    return 16'd62259;
      2'd1:    return 16'd6554;
      default: return 16'd9830;
    endcase
  endfunction

  // Blend two presets by t/256 with rounding.
  function automatic logic [FRAC_W-1:0] env_interp(input logic [FRAC_W-1:0] lo_v,
                                                   input logic [FRAC_W-1:0] hi_v,
                                                   input logic [7:0] t);
    logic [25:0] acc;
    acc = 26'(lo_v) * 26'(9'd256 - 9'(t)) + 26'(hi_v) * 26'(t) + 26'd128;
    return acc[23:8];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [31:0] v);
    if (v > SAT_HI) begin
      return 16'sh7FFF;
    end else if (v < SAT_LO) begin
      return 16'sh8000;
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/gvm_in_if.sv */
// Input item channel: valid/ready plus the item fields.
`default_nettype none

interface gvm_in_if import gvm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [ADDR_W-1:0]          corpus_address;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       dry_valid;
  logic [SLICE_W-1:0]         slice_length;
  logic [RAND_W-1:0]          random_value;

  modport source(output valid, output operation, output corpus_address,
                 output sample_value, output dry_valid, output slice_length,
                 output random_value, input ready);
  modport sink(input valid, input operation, input corpus_address,
               input sample_value, input dry_valid, input slice_length,
               input random_value, output ready);
endinterface

`default_nettype wire

/* rtl/gvm_out_if.sv */
// Result channel: valid/ready plus the mixed sample.
`default_nettype none

interface gvm_out_if import gvm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;

  modport source(output valid, output out_sample, input ready);
  modport sink(input valid, input out_sample, output ready);
endinterface

`default_nettype wire

/* rtl/gvm_div.sv */
// Bit-serial restoring divider for the envelope ramps, one quotient bit a cycle.
`default_nettype none

module gvm_div import gvm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_Q_W-1:0]   quo
);

  localparam int SH_W  = DIV_DEN_W + DIV_Q_W - 1;
  localparam int CNT_W = $clog2(DIV_Q_W + 1);

  logic [DIV_NUM_W-1:0] rem;
  logic [SH_W-1:0]      dsh;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 ge;

  assign ge = rem >= DIV_NUM_W'(dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient is known to stay below 2^DIV_Q_W, so start at the top quotient bit.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, {(DIV_Q_W-1){1'b0}}};
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - DIV_NUM_W'(dsh);
      end
      quo <= {quo[DIV_Q_W-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

endmodule

`default_nettype wire

/* rtl/gvm_grain.sv */
// Grain setup: length jitter, clamping and envelope fractions for a new voice.
`default_nettype none

module gvm_grain import gvm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [GLEN_W-1:0]  glen,
  input  logic [ENV_W-1:0]   env,
  input  logic [SPM_W-1:0]   spm,
  input  logic [ADDR_W-1:0]  address,
  input  logic [SLICE_W-1:0] slice,
  input  logic [RAND_W-1:0]  rnd,
  output logic               done,
  output voice_t             rec
);

  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_MOD  = 2'd1;
  localparam logic [1:0] G_ENV  = 2'd2;
  localparam logic [1:0] G_END  = 2'd3;
  localparam int CNT_W = $clog2(RAND_W);

  logic [1:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic [RAND_W-1:0]  rnd_r;
  logic [SLICE_W-1:0] slice_r;
  logic [9:0]         rem;
  logic [8:0]         range_v;
  logic [9:0]         modulus;
  logic [10:0]        trial;
  logic [ENV_W-1:0]   ep;
  logic [1:0]         lo;
  logic [1:0]         hi;
  logic [MS_W-1:0]    ms_raw;
  logic [MS_W-1:0]    ms_r;
  logic [19:0]        len;

  assign range_v = glen[GLEN_W-1:2];
  assign modulus = {range_v, 1'b1};
  assign trial   = {rem, rnd_r[RAND_W-1]};
  assign ep      = (env > ENV_MAX) ? ENV_MAX : env;
  assign lo      = ep[9:8];
  assign hi      = (lo == PRESET_LAST) ? PRESET_LAST : lo + 2'd1;
  assign ms_raw  = MS_W'(glen) + MS_W'(rem) - MS_W'(range_v);
  assign len     = 20'(spm) * 20'(ms_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        G_IDLE: begin
          if (start) begin
            state <= G_MOD;
            cnt   <= CNT_W'(RAND_W - 1);
          end
        end
        G_MOD: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= G_ENV;
          end
        end
        G_ENV: state <= G_END;
        G_END: begin
          state <= G_IDLE;
          done  <= 1'b1;
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      G_IDLE: begin
        if (start) begin
          rnd_r     <= rnd;
          slice_r   <= slice;
          rem       <= '0;
          rec.start <= address;
          rec.pos   <= '0;
        end
      end
      G_MOD: begin
        // Long division of the random word, one bit a step; keep the remainder.
        rem   <= (trial >= {1'b0, modulus}) ? 10'(trial - {1'b0, modulus}) : trial[9:0];
        rnd_r <= rnd_r << 1;
      end
      G_ENV: begin
        ms_r    <= (ms_raw < MIN_GRAIN_MS) ? MIN_GRAIN_MS : ms_raw;
        rec.att <= env_interp(att_preset(lo), att_preset(hi), ep[7:0]);
      end
      G_END: begin
        rec.dec  <= env_interp(dec_preset(lo), dec_preset(hi), ep[7:0]);
        rec.stop <= (len > 20'(slice_r)) ? slice_r : len[POS_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/granular_voice_mixer.sv */
// Top level: corpus and voice memories, render sequencer and dry/wet mix.
//
//  channel  | dir | handshake           | payload
//  in_ch    | in  | valid / ready       | operation, corpus_address, sample_value,
//           |     |                     | dry_valid, slice_length, random_value
//  out_ch   | out | valid / ready       | out_sample
//  cfg      | in  | cfg_write (no wait) | cfg_index, cfg_data
//
// Grain start waits on the bit-serial modulo. Render reads and checks each voice;
// an active one fetches a sample, and one in a ramp also waits on the shared
// divider; then come ST_MIX1, with pass on ST_MIX2 and ST_MIX3, and ST_OUT, which
// loads the output register. Reset clears control state and all voice active
// bits; the corpus is not cleared. A stalled output holds; the next item is taken
// while it waits unless a further render needs the output register.
`default_nettype none

module granular_voice_mixer import gvm_pkg::*; #(
  parameter int VOICE_COUNT  = DEF_VOICE_COUNT,
  parameter int CORPUS_DEPTH = DEF_CORPUS_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  gvm_in_if.sink                 in_ch,
  gvm_out_if.source              out_ch,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int VI_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int AW    = (CORPUS_DEPTH > 1) ? $clog2(CORPUS_DEPTH) : 1;
  localparam int CA_W  = (AW > POS_W + 1) ? AW : POS_W + 1;
  localparam int SUM_W = SAMPLE_W + 1 + $clog2(VOICE_COUNT + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_GRAIN = 4'd1;
  localparam logic [3:0] ST_VRD   = 4'd2;
  localparam logic [3:0] ST_VCHK  = 4'd3;
  localparam logic [3:0] ST_SMP   = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_MIX1  = 4'd6;
  localparam logic [3:0] ST_MIX2  = 4'd7;
  localparam logic [3:0] ST_MIX3  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  // Configuration registers
  logic [GLEN_W-1:0] glen;
  logic [ENV_W-1:0]  env;
  logic [SPM_W-1:0]  spm;
  logic              pass;
  logic [MIX_W-1:0]  mix;

  // Memories
  logic [SAMPLE_W-1:0] corpus [CORPUS_DEPTH];
  voice_t              voice_mem [VOICE_COUNT];
  logic [SAMPLE_W-1:0] corpus_rd;
  voice_t              voice_rd;

  // Control
  logic [3:0]             state;
  logic [VI_W-1:0]        vidx;
  logic [VI_W-1:0]        slot;
  logic [VOICE_COUNT-1:0] active;
  logic                   out_valid;
  logic signed [SAMPLE_W-1:0] out_data;

  // Datapath registers
  logic signed [SUM_W-1:0]    sum;
  logic [DIV_DEN_W-1:0]       pa;
  logic [DIV_DEN_W:0]         pd;
  logic                       neg_r;
  logic signed [SAMPLE_W-1:0] dry_r;
  logic signed [SAMPLE_W-1:0] res_r;
  logic signed [25:0]         pdry;
  logic signed [25:0]         pwet;

  // Combinational
  logic                       accept;
  logic                       out_load;
  logic                       grain_start;
  logic                       grain_done;
  voice_t                     grain_rec;
  logic                       act;
  logic                       adv;
  logic [POS_W-1:0]           pos_inc;
  logic                       last;
  logic                       vwe;
  logic [VI_W-1:0]            vwa;
  voice_t                     vwd;
  logic [CA_W-1:0]            raddr_full;
  logic [CA_W-1:0]            waddr_full;
  logic signed [SAMPLE_W-1:0] s;
  logic [SAMPLE_W:0]          s_ext;
  logic [SAMPLE_W:0]          mag17;
  logic [DIV_DEN_W-1:0]       p65;
  logic                       atk;
  logic                       dcy;
  logic [POS_W-1:0]           ramp_len;
  logic [DIV_DEN_W-1:0]       prod;
  logic                       div_start;
  logic [DIV_NUM_W-1:0]       div_num;
  logic [DIV_DEN_W-1:0]       div_den;
  logic                       div_done;
  logic [DIV_Q_W-1:0]         div_q;
  logic signed [SUM_W-1:0]    qs;
  logic [MIX_W-1:0]           mixs;
  logic signed [26:0]         mt;
  logic signed [26:0]         mq;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && !rst;
  assign grain_start = accept && (in_ch.operation == OP_GRAIN);
  assign out_ch.valid      = out_valid;
  assign out_ch.out_sample = out_data;
  // Load the output register once it is free or being drained.
  assign out_load    = (state == ST_OUT) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      glen <= GLEN_RESET;
      env  <= ENV_RESET;
      spm  <= SPM_RESET;
      pass <= 1'b0;
      mix  <= MIX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRAIN_LEN: glen <= cfg_data[GLEN_W-1:0];
        REG_ENV_SHAPE: env  <= cfg_data[ENV_W-1:0];
        REG_SPM:       spm  <= cfg_data[SPM_W-1:0];
        REG_PASS:      pass <= cfg_data[0];
        REG_MIX:       mix  <= cfg_data[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  gvm_grain u_grain (
    .clk     (clk),
    .rst     (rst),
    .start   (grain_start),
    .glen    (glen),
    .env     (env),
    .spm     (spm),
    .address (in_ch.corpus_address),
    .slice   (in_ch.slice_length),
    .rnd     (in_ch.random_value),
    .done    (grain_done),
    .rec     (grain_rec)
  );

  gvm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  // Voice evaluation
  assign act     = active[vidx];
  assign adv     = voice_rd.pos < voice_rd.stop;
  assign pos_inc = voice_rd.pos + 1'b1;
  assign last    = (vidx == VI_W'(VOICE_COUNT - 1));

  assign raddr_full = CA_W'(voice_rd.start) + CA_W'(voice_rd.pos);
  assign waddr_full = CA_W'(in_ch.corpus_address);

  assign s     = signed'(corpus_rd);
  assign s_ext = {s[SAMPLE_W-1], s};
  assign mag17 = s[SAMPLE_W-1] ? (~s_ext + 1'b1) : s_ext;
  assign p65   = {voice_rd.pos, {FRAC_W{1'b0}}};
  assign atk   = p65 < pa;
  assign dcy   = {1'b0, p65} > pd;
  assign ramp_len = atk ? voice_rd.pos : voice_rd.stop - voice_rd.pos;
  assign prod  = DIV_DEN_W'(mag17[SAMPLE_W-1:0]) * DIV_DEN_W'(ramp_len);

  assign div_start = (state == ST_SMP) && (atk || dcy);
  assign div_num   = {prod, {FRAC_W{1'b0}}};
  assign div_den   = atk ? pa : DIV_DEN_W'(voice_rd.dec) * DIV_DEN_W'(voice_rd.stop);
  assign qs        = signed'(SUM_W'(div_q));

  assign mixs = (mix > MIX_FULL) ? MIX_FULL : mix;
  assign mt   = 27'(pdry) + 27'(pwet);
  assign mq   = (mt + ((mt < 0) ? 27'sd255 : 27'sd0)) >>> 8;

  // Voice memory write: new grain, or position advance during render
  always_comb begin
    vwe = 1'b0;
    vwa = vidx;
    vwd = voice_rd;
    vwd.pos = pos_inc;
    if (grain_done) begin
      vwe = 1'b1;
      vwa = slot;
      vwd = grain_rec;
    end else if (state == ST_VCHK && act && adv) begin
      vwe = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      voice_mem[vwa] <= vwd;
    end
    if (state == ST_VRD) begin
      voice_rd <= voice_mem[vidx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.operation == OP_WRITE) begin
      corpus[waddr_full[AW-1:0]] <= in_ch.sample_value;
    end
    if (state == ST_VCHK) begin
      corpus_rd <= corpus[raddr_full[AW-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vidx      <= '0;
      slot      <= '0;
      active    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_ch.operation)
              OP_GRAIN: state <= ST_GRAIN;
              OP_RENDER: begin
                vidx  <= '0;
                state <= ST_VRD;
              end
              default: ;
            endcase
          end
        end
        ST_GRAIN: begin
          if (grain_done) begin
            active[slot] <= 1'b1;
            slot  <= (slot == VI_W'(VOICE_COUNT - 1)) ? '0 : slot + 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_VRD: state <= ST_VCHK;
        ST_VCHK: begin
          if (act && adv) begin
            active[vidx] <= (pos_inc < voice_rd.stop);
            state <= ST_SMP;
          end else begin
            active[vidx] <= 1'b0;
            vidx  <= last ? vidx : vidx + 1'b1;
            state <= last ? ST_MIX1 : ST_VRD;
          end
        end
        ST_SMP: begin
          if (atk || dcy) begin
            state <= ST_DIV;
          end else begin
            vidx  <= last ? vidx : vidx + 1'b1;
            state <= last ? ST_MIX1 : ST_VRD;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            vidx  <= last ? vidx : vidx + 1'b1;
            state <= last ? ST_MIX1 : ST_VRD;
          end
        end
        ST_MIX1: state <= pass ? ST_MIX2 : ST_OUT;
        ST_MIX2: state <= ST_MIX3;
        ST_MIX3: state <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept && in_ch.operation == OP_RENDER) begin
      sum   <= '0;
      dry_r <= in_ch.dry_valid ? in_ch.sample_value : '0;
    end
    if (state == ST_VCHK) begin
      pa <= DIV_DEN_W'(voice_rd.att) * DIV_DEN_W'(voice_rd.stop);
      pd <= (DIV_DEN_W+1)'(17'h10000 - 17'(voice_rd.dec)) * (DIV_DEN_W+1)'(voice_rd.stop);
    end
    if (state == ST_SMP) begin
      neg_r <= s[SAMPLE_W-1];
      if (!(atk || dcy)) begin
        sum <= sum + SUM_W'(s);
      end
    end
    if (state == ST_DIV && div_done) begin
      sum <= neg_r ? sum - qs : sum + qs;
    end
    if (state == ST_MIX1) begin
      res_r <= sat16(32'(sum));
    end
    if (state == ST_MIX2) begin
      pdry <= 26'(dry_r) * 26'(signed'({1'b0, MIX_FULL - mixs}));
      pwet <= 26'(res_r) * 26'(signed'({1'b0, mixs}));
    end
    if (state == ST_MIX3) begin
      res_r <= sat16(32'(mq));
    end
    if (out_load) begin
      out_data <= res_r;
    end
  end

`ifndef SYNTH
  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the ramp state");

  a_grain_in_grain_state: assert property (@(posedge clk) disable iff (rst)
    grain_done |-> state == ST_GRAIN)
    else $error("grain setup finished outside the grain state");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= VI_W'(VOICE_COUNT - 1) && vidx <= VI_W'(VOICE_COUNT - 1))
    else $error("voice index out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

/* tb/gvm_mix_monitor.sv */
// Watches the mixer channels, predicts every rendered sample and compares it.
`timescale 1ns / 1ps

module gvm_mix_monitor import gvm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  gvm_in_if                      in_mon,
  gvm_out_if                     out_mon,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     pending,
  output int                     errors
);

  localparam int NV = DEF_VOICE_COUNT;
  localparam longint ATT_TAB [3] = '{3277, 6554, 55706};
  localparam longint DEC_TAB [3] = '{62259, 6554, 9830};

  logic signed [SAMPLE_W-1:0] corpus_mem [0:DEF_CORPUS_DEPTH-1];
  logic [ADDR_W-1:0] v_start [NV];
  longint            v_pos   [NV];
  longint            v_stop  [NV];
  longint            v_att   [NV];
  longint            v_dec   [NV];
  bit                v_on    [NV];
  int                slot;

  logic [GLEN_W-1:0] glen;
  logic [ENV_W-1:0]  env;
  logic [SPM_W-1:0]  spm;
  logic              pass_en;
  logic [MIX_W-1:0]  mix;

  logic signed [SAMPLE_W-1:0] expected_samples [$];

  assign pending = expected_samples.size();

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint voice_gain(input int v);
    longint s, p, e;
    s = corpus_mem[16'(v_start[v] + v_pos[v])];
    p = v_pos[v];
    e = v_stop[v];
    if (p * 65536 < v_att[v] * e) return (s * p * 65536) / (v_att[v] * e);
    if (p * 65536 > (65536 - v_dec[v]) * e) return (s * (e - p) * 65536) / (v_dec[v] * e);
    return s;
  endfunction

  function automatic void start_voice(input logic [ADDR_W-1:0] a,
                                      input logic [SLICE_W-1:0] sl,
                                      input logic [RAND_W-1:0] r);
    longint rng, jit, ms, stop, ep, lo, hi, t;
    rng = glen / 4;
    jit = 0;
    if (rng > 0) jit = longint'(r % (2 * rng + 1)) - rng;
    ms = glen + jit;
    if (ms < 20) ms = 20;
    stop = spm * ms;
    if (stop > sl) stop = sl;
    ep = (env > ENV_MAX) ? ENV_MAX : env;
    lo = ep >> 8;
    hi = (lo + 1 > 2) ? 2 : lo + 1;
    t = ep & 255;
    v_start[slot] = a;
    v_pos[slot]   = 0;
    v_stop[slot]  = stop;
    v_on[slot]    = 1;
    v_att[slot]   = (ATT_TAB[lo] * (256 - t) + ATT_TAB[hi] * t + 128) >> 8;
    v_dec[slot]   = (DEC_TAB[lo] * (256 - t) + DEC_TAB[hi] * t + 128) >> 8;
    slot = (slot + 1) % NV;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] mix_render(
      input logic signed [SAMPLE_W-1:0] dry_in, input logic dv);
    longint sum, wet, m, dry;
    sum = 0;
    for (int v = 0; v < NV; v++) begin
      if (v_on[v]) begin
        if (v_pos[v] < v_stop[v]) begin
          sum += voice_gain(v);
          v_pos[v]++;
        end
        if (v_pos[v] >= v_stop[v]) v_on[v] = 0;
      end
    end
    wet = clip16(sum);
    if (pass_en) begin
      m = (mix > MIX_FULL) ? 256 : mix;
      dry = dv ? longint'(dry_in) : 0;
      wet = clip16((dry * (256 - m) + wet * m) / 256);
    end
    return wet[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      for (int v = 0; v < NV; v++) begin
        v_on[v] = 0; v_pos[v] = 0; v_stop[v] = 0; v_start[v] = '0;
        v_att[v] = 0; v_dec[v] = 0;
      end
      slot = 0;
      glen = GLEN_RESET; env = ENV_RESET; spm = SPM_RESET;
      pass_en = 1'b0; mix = MIX_RESET;
      expected_samples.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GRAIN_LEN: glen    = cfg_data[GLEN_W-1:0];
          REG_ENV_SHAPE: env     = cfg_data[ENV_W-1:0];
          REG_SPM:       spm     = cfg_data[SPM_W-1:0];
          REG_PASS:      pass_en = cfg_data[0];
          REG_MIX:       mix     = cfg_data[MIX_W-1:0];
          default: ;
        endcase
      end
      // retire the output transfer first: it belongs to an older item
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected out_sample, expected none got %0d",
                   $time, out_mon.out_sample);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_mon.out_sample !== want) begin
            $display("%0t: out_sample mismatch, expected %0d got %0d",
                     $time, want, out_mon.out_sample);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.operation)
          OP_WRITE:  corpus_mem[in_mon.corpus_address] = in_mon.sample_value;
          OP_GRAIN:  start_voice(in_mon.corpus_address, in_mon.slice_length,
                                 in_mon.random_value);
          OP_RENDER: expected_samples.insert(expected_samples.size(),
                                             mix_render(in_mon.sample_value,
                                                        in_mon.dry_valid));
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/granular_voice_mixer_tb.sv */
// Stimulus, idling and verdict for the granular voice mixer regression.
`timescale 1ns / 1ps

module granular_voice_mixer_tb;
  import gvm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int pending, errors;

  gvm_in_if  in_ch();
  gvm_out_if out_ch();

  granular_voice_mixer u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gvm_mix_monitor u_mon (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bit filled [0:DEF_CORPUS_DEPTH-1];
  int send_pct, recv_pct, items, idle_cnt;
  bit hold_req;
  int cur_glen, cur_spm;
  logic [ADDR_W-1:0] run_base;
  int run_size;

  // receiver: random stalls, or one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt == IDLE_LIMIT) begin
        $display("granular_voice_mixer regression: fail");
        $finish;
      end
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a,
                      input logic [SAMPLE_W-1:0] s, input logic d,
                      input logic [SLICE_W-1:0] sl, input logic [RAND_W-1:0] r);
    in_ch.operation      <= op;
    in_ch.corpus_address <= a;
    in_ch.sample_value   <= s;
    in_ch.dry_valid      <= d;
    in_ch.slice_length   <= sl;
    in_ch.random_value   <= r;
    in_ch.valid          <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items++;
    if (op == OP_WRITE) filled[a] = 1;
    // idle each cycle with the sender's share before the next offer
    while ($urandom_range(0, 99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold input until every rendered sample is out, then let a grain start finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_regs(input int g, input int e, input int sp, input int p, input int m);
    cfg_write <= 1'b1;
    cfg_index <= REG_GRAIN_LEN; cfg_data <= CFG_DATA_W'(g); @(posedge clk);
    cfg_index <= REG_ENV_SHAPE; cfg_data <= CFG_DATA_W'(e); @(posedge clk);
    cfg_index <= REG_SPM;       cfg_data <= CFG_DATA_W'(sp); @(posedge clk);
    cfg_index <= REG_PASS;      cfg_data <= CFG_DATA_W'(p); @(posedge clk);
    cfg_index <= REG_MIX;       cfg_data <= CFG_DATA_W'(m); @(posedge clk);
    cfg_write <= 1'b0;
    cur_glen = g;
    cur_spm  = sp;
  endtask

  function automatic int written_run(input logic [ADDR_W-1:0] a, input int cap);
    int n;
    n = 0;
    while (n < cap && filled[ADDR_W'(a + n)]) n++;
    return n;
  endfunction

  // natural grain length in samples, before the slice cap
  function automatic longint grain_samples(input logic [RAND_W-1:0] r);
    longint rng, ms;
    rng = cur_glen / 4;
    ms = cur_glen;
    if (rng > 0) ms = cur_glen + longint'(r % (2 * rng + 1)) - rng;
    if (ms < 20) ms = 20;
    return ms * cur_spm;
  endfunction

  task automatic fill_run();
    logic [ADDR_W-1:0] base;
    int len;
    base = ADDR_W'($urandom);
    len = $urandom_range(8, 48);
    for (int i = 0; i < len; i++)
      send(OP_WRITE, ADDR_W'(base + i), SAMPLE_W'($urandom), 1'($urandom),
           SLICE_W'($urandom_range(0, 65536)), $urandom);
    run_base = base;
    run_size = len;
  endtask

  task automatic start_grain();
    logic [ADDR_W-1:0] a;
    logic [RAND_W-1:0] r;
    int c;
    logic [SLICE_W-1:0] sl;
    a = ADDR_W'(run_base + $urandom_range(0, run_size - 1));
    c = written_run(a, DEF_CORPUS_DEPTH);
    r = $urandom;
    // only a slice the written corpus covers, unless the grain ends sooner anyway
    if (grain_samples(r) <= c && $urandom_range(0, 1)) sl = SLICE_W'($urandom_range(0, 65536));
    else sl = SLICE_W'($urandom_range(0, c));
    send(OP_GRAIN, a, SAMPLE_W'($urandom), 1'($urandom), sl, r);
  endtask

  task automatic render();
    send(OP_RENDER, ADDR_W'($urandom), SAMPLE_W'($urandom), 1'($urandom),
         SLICE_W'($urandom_range(0, 65536)), $urandom);
  endtask

  int setting [6][5] = '{
    '{200, 256, 96, 0, 256},
    '{20, 0, 1, 1, 0},
    '{2047, 1023, 255, 1, 511},
    '{37, 128, 3, 1, 128},
    '{1, 384, 7, 0, 256},
    '{600, 512, 2, 1, 77}
  };

  initial begin
    int target, k;
    bit pressed, paused;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.corpus_address = '0;
    in_ch.sample_value = '0;
    in_ch.dry_valid = 1'b0;
    in_ch.slice_length = '0;
    in_ch.random_value = '0;
    cfg_write = 1'b0;
    cfg_index = REG_GRAIN_LEN;
    cfg_data = '0;
    hold_req = 0;
    items = 0;
    run_size = 0;
    send_pct = 21;
    recv_pct = 57;
    pressed = 0;
    paused = 0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero samples per ms: every grain has zero length
    set_regs(20, 0, 0, 1, 128);
    send(OP_WRITE, 16'hFFFF, 16'h7FFF, 1'b0, 17'd0, 32'd0);
    send(OP_WRITE, 16'h0000, 16'h8000, 1'b1, 17'h1FFFF, 32'hFFFFFFFF);
    send(OP_WRITE, 16'h0001, 16'h1234, 1'b0, 17'd0, 32'd0);
    send(OP_RENDER, 16'h0000, 16'h8000, 1'b1, 17'd0, 32'd0);
    send(OP_RENDER, 16'hFFFF, 16'h7FFF, 1'b0, 17'd0, 32'd0);
    send(OP_GRAIN, 16'hFFFF, 16'h0000, 1'b0, 17'd65536, 32'hFFFFFFFF);
    send(OP_RENDER, 16'h0000, 16'h7FFF, 1'b1, 17'd0, 32'd0);
    send(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 17'h1FFFF, 32'hFFFFFFFF);
    send(OP_RENDER, 16'h0000, 16'h8000, 1'b1, 17'd0, 32'd0);
    drain();
    // short grain wrapping the corpus end, then a zero-length slice
    set_regs(20, 0, 1, 1, 256);
    send(OP_GRAIN, 16'hFFFF, 16'h0000, 1'b0, 17'd3, 32'd0);
    repeat (4) send(OP_RENDER, 16'h0000, 16'h8000, 1'b1, 17'd0, 32'd0);
    send(OP_GRAIN, 16'h0000, 16'h0000, 1'b0, 17'd0, 32'd0);
    send(OP_RENDER, 16'h0000, 16'h7FFF, 1'b1, 17'd0, 32'd0);
    send(OP_RENDER, 16'h0000, 16'h7FFF, 1'b0, 17'd0, 32'd0);

    for (int p = 0; p < 6; p++) begin
      drain();
      set_regs(setting[p][0], setting[p][1], setting[p][2], setting[p][3], setting[p][4]);
      if (p < 2) begin
        send_pct = 21; recv_pct = 57;
      end else if (p < 4) begin
        send_pct = 57; recv_pct = 21;
      end else begin
        send_pct = 0; recv_pct = 0;
      end
      target = items + 300;
      fill_run();
      while (items < target) begin
        k = $urandom_range(0, 99);
        if (k < 10) fill_run();
        else if (k < 30) start_grain();
        else if (k < 35) send(OP_WRITE, ADDR_W'($urandom), SAMPLE_W'($urandom),
                              1'($urandom), SLICE_W'($urandom_range(0, 65536)),
                              $urandom);
        else if (k < 37) send(OP_UNUSED, ADDR_W'($urandom), SAMPLE_W'($urandom),
                              1'($urandom), SLICE_W'($urandom_range(0, 65536)),
                              $urandom);
        else render();
        if (p == 1 && !pressed && items > target - 150) begin
          pressed = 1;
          hold_req = 1;
          repeat (4) start_grain();
          repeat (40) render();
        end
        if (p == 3 && !paused && items > target - 150) begin
          paused = 1;
          drain();
        end
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("granular_voice_mixer regression: pass");
    end else begin
      $display("granular_voice_mixer regression: fail");
    end
    $finish;
  end

endmodule

/* granular_voice_mixer.f */
rtl/gvm_pkg.sv
rtl/gvm_in_if.sv
rtl/gvm_out_if.sv
rtl/gvm_div.sv
rtl/gvm_grain.sv
rtl/granular_voice_mixer.sv
tb/gvm_mix_monitor.sv
tb/granular_voice_mixer_tb.sv
